// File: hw/rtl/lkbs_pkg.sv
`timescale 1ns / 1ps
package lkbs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_CHARS   = 32;
  localparam int SLOTS       = MAX_CHARS + 1;
  localparam int KEY_DEPTH   = TABLE_DEPTH * SLOTS;
  localparam int KEY_AW      = $clog2(KEY_DEPTH);
  localparam int ENT_AW      = $clog2(TABLE_DEPTH);
  localparam int SLOT_AW     = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DIFF_W      = 8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_MASK  = 8'h5F;

  typedef enum logic [1:0] {
    CMD_KEY_CHAR  = 2'd0,
    CMD_VALUE     = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT = 2'd0,
    CFG_EXACT_MODE  = 2'd1,
    CFG_PREFIX_MODE = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] entry;
    logic [5:0] position;
    logic [7:0] char_code;
    logic [7:0] entry_value;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [7:0] match_value;
    logic [5:0] match_index;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             exact;
    logic             prefix;
  } srch_req_t;

  typedef struct packed {
    logic [KEY_AW-1:0]  key_waddr;
    logic               key_we;
    logic [7:0]         key_wdata;
    logic [ENT_AW-1:0]  val_waddr;
    logic               val_we;
    logic [7:0]         val_wdata;
    logic [SLOT_AW-1:0] qry_waddr;
    logic               qry_we;
    logic [7:0]         qry_wdata;
  } mem_wr_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? (c & CASE_MASK) : c;
  endfunction

endpackage

// File: hw/rtl/lkbs_ram.sv
`timescale 1ns / 1ps
module lkbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lkbs_front.sv
`timescale 1ns / 1ps
module lkbs_front import lkbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_word_t         in_word,
  input  logic [CNT_W-1:0] entry_count,
  input  logic             exact_mode,
  input  logic             prefix_mode,
  output mem_wr_t          wr,
  output logic             req_valid,
  input  logic             req_ready,
  output srch_req_t        req,
  input  logic             srch_done
);

  logic             busy_r, busy_nxt;
  logic             term_r, term_nxt;
  logic             req_valid_r, req_valid_nxt;
  logic [6:0]       term_pos_r, term_pos_nxt;
  srch_req_t        req_r, req_nxt;
  logic             accept;
  logic             pos_ok;
  logic [CNT_W-1:0] count_clip;

  assign in_full = busy_r;
  assign accept  = in_push && !busy_r;
  assign pos_ok  = 32'(in_word.position) < SLOTS;
  assign count_clip = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : entry_count;

  always_comb begin
    wr = '0;
    wr.key_waddr = KEY_AW'(KEY_AW'(in_word.entry) * KEY_AW'(SLOTS) + KEY_AW'(in_word.position));
    wr.key_wdata = in_word.char_code;
    wr.val_waddr = ENT_AW'(in_word.entry);
    wr.val_wdata = in_word.entry_value;
    wr.qry_waddr = SLOT_AW'(in_word.position);
    wr.qry_wdata = in_word.char_code;
    busy_nxt      = busy_r;
    term_nxt      = term_r;
    term_pos_nxt  = term_pos_r;
    req_valid_nxt = req_valid_r;
    req_nxt       = req_r;
    if (accept) begin
      case (in_word.cmd)
        CMD_KEY_CHAR: wr.key_we = pos_ok;
        CMD_VALUE:    wr.val_we = 1'b1;
        CMD_QUERY: begin
          wr.qry_we = pos_ok;
          if (in_word.last) begin
            busy_nxt     = 1'b1;
            term_nxt     = 1'b1;
            term_pos_nxt = 7'(in_word.position) + 7'd1;
          end
        end
        default: ;
      endcase
    end
    if (term_r) begin
      // store the terminator, then hand the search over
      wr.qry_waddr  = SLOT_AW'(term_pos_r);
      wr.qry_wdata  = '0;
      wr.qry_we     = 32'(term_pos_r) < SLOTS;
      term_nxt      = 1'b0;
      req_valid_nxt = 1'b1;
      req_nxt       = '{count: count_clip, exact: exact_mode, prefix: prefix_mode};
    end
    if (req_valid_r && req_ready) begin
      req_valid_nxt = 1'b0;
    end
    if (srch_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      term_r      <= 1'b0;
      req_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      term_r      <= term_nxt;
      req_valid_r <= req_valid_nxt;
    end
    term_pos_r <= term_pos_nxt;
    req_r      <= req_nxt;
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

// File: hw/rtl/lkbs_back.sv
`timescale 1ns / 1ps
module lkbs_back import lkbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  srch_req_t          req,
  output logic               srch_done,
  output logic [KEY_AW-1:0]  key_raddr,
  input  logic [7:0]         key_rdata,
  output logic [SLOT_AW-1:0] qry_raddr,
  input  logic [7:0]         qry_rdata,
  output logic [ENT_AW-1:0]  val_raddr,
  input  logic [7:0]         val_rdata,
  output logic               out_empty,
  input  logic               out_pop,
  output out_word_t          out_word
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PROBE  = 9'b000000010,
    S_LEN_RD = 9'b000000100,
    S_LEN_EV = 9'b000001000,
    S_CMP_RD = 9'b000010000,
    S_CMP_EV = 9'b000100000,
    S_VAL_RD = 9'b001000000,
    S_VAL_EV = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    low_r, low_nxt;
  logic [CNT_W-1:0]    hi1_r, hi1_nxt;
  logic [ENT_AW-1:0]   mid_r, mid_nxt;
  logic [KEY_AW-1:0]   base_r, base_nxt;
  logic [SLOT_AW-1:0]  si_r, si_nxt;
  logic [SLOT_AW-1:0]  ti_r, ti_nxt;
  logic [SLOT_AW-1:0]  left_r, left_nxt;
  logic [DIFF_W-1:0]   diff_r, diff_nxt;
  logic                exact_r, exact_nxt;
  logic                prefix_r, prefix_nxt;
  out_word_t           pend_r, pend_nxt;
  out_word_t           res_r, res_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic [CNT_W:0]      mid_sum;
  logic [7:0]          s, t, cs, ct;
  logic                res_go, res_neg, res_pos;

  assign mid_sum = (CNT_W+1)'(low_r) + (CNT_W+1)'(hi1_r) - (CNT_W+1)'(1);
  assign s  = (32'(si_r) < SLOTS) ? qry_rdata : 8'd0;
  assign t  = (32'(ti_r) < SLOTS) ? key_rdata : 8'd0;
  assign cs = upcase(s);
  assign ct = upcase(t);

  assign req_ready = (state_r == S_IDLE);
  assign srch_done = (state_r == S_DONE) && (!res_valid_r || out_pop);
  assign qry_raddr = si_r;
  assign val_raddr = mid_r;
  assign key_raddr = base_r + KEY_AW'(state_r == S_LEN_RD ? left_r : ti_r);

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi1_nxt       = hi1_r;
    mid_nxt       = mid_r;
    base_nxt      = base_r;
    si_nxt        = si_r;
    ti_nxt        = ti_r;
    left_nxt      = left_r;
    diff_nxt      = diff_r;
    exact_nxt     = exact_r;
    prefix_nxt    = prefix_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    res_go        = 1'b0;
    res_neg       = 1'b0;
    res_pos       = 1'b0;
    if (res_valid_r && out_pop) begin
      res_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          low_nxt    = '0;
          hi1_nxt    = req.count;
          exact_nxt  = req.exact;
          prefix_nxt = req.prefix;
          state_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (low_r < hi1_r) begin
          mid_nxt   = ENT_AW'(mid_sum >> 1);
          base_nxt  = KEY_AW'(KEY_AW'(ENT_AW'(mid_sum >> 1)) * KEY_AW'(SLOTS));
          si_nxt    = '0;
          ti_nxt    = '0;
          diff_nxt  = '0;
          left_nxt  = prefix_r ? '0 : SLOT_AW'(MAX_CHARS);
          state_nxt = prefix_r ? S_LEN_RD : S_CMP_RD;
        end else begin
          pend_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_LEN_RD: begin
        // length scan: left_r counts keyword characters
        state_nxt = (32'(left_r) == SLOTS) ? S_CMP_RD : S_LEN_EV;
      end
      S_LEN_EV: begin
        if (key_rdata == 8'd0) begin
          state_nxt = S_CMP_RD;
        end else begin
          left_nxt  = left_r + SLOT_AW'(1);
          state_nxt = S_LEN_RD;
        end
      end
      S_CMP_RD: begin
        if (left_r == '0) begin
          res_go  = 1'b1;
          res_pos = diff_r != '0;
        end else begin
          state_nxt = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        state_nxt = S_CMP_RD;
        if (s == t) begin
          if (s == 8'd0) begin
            res_go  = 1'b1;
            res_pos = diff_r != '0;
          end else begin
            si_nxt   = si_r + SLOT_AW'(1);
            ti_nxt   = ti_r + SLOT_AW'(1);
            left_nxt = left_r - SLOT_AW'(1);
          end
        end else begin
          diff_nxt = diff_r + DIFF_W'(exact_r);
          // blanks are skipped without spending the limit
          if (s == CHAR_SPACE) begin
            si_nxt = si_r + SLOT_AW'(1);
          end else if (t == CHAR_SPACE) begin
            ti_nxt = ti_r + SLOT_AW'(1);
          end else if (cs == ct) begin
            si_nxt   = si_r + SLOT_AW'(1);
            ti_nxt   = ti_r + SLOT_AW'(1);
            left_nxt = left_r - SLOT_AW'(1);
          end else begin
            res_go  = 1'b1;
            res_neg = cs < ct;
            res_pos = cs > ct;
          end
        end
      end
      S_VAL_RD: state_nxt = S_VAL_EV;
      S_VAL_EV: begin
        pend_nxt  = '{found: 1'b1, match_value: val_rdata, match_index: 6'(mid_r)};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_r || out_pop) begin
          res_nxt       = pend_r;
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (res_go) begin
      if (res_neg) begin
        hi1_nxt   = CNT_W'(mid_r);
        state_nxt = S_PROBE;
      end else if (res_pos) begin
        low_nxt   = CNT_W'(mid_r) + CNT_W'(1);
        state_nxt = S_PROBE;
      end else begin
        state_nxt = S_VAL_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    low_r    <= low_nxt;
    hi1_r    <= hi1_nxt;
    mid_r    <= mid_nxt;
    base_r   <= base_nxt;
    si_r     <= si_nxt;
    ti_r     <= ti_nxt;
    left_r   <= left_nxt;
    diff_r   <= diff_nxt;
    exact_r  <= exact_nxt;
    prefix_r <= prefix_nxt;
    pend_r   <= pend_nxt;
    res_r    <= res_nxt;
  end

  assign out_empty = !res_valid_r;
  assign out_word  = res_r;

endmodule

// File: hw/rtl/loose_keyword_binary_search_unit.sv
`timescale 1ns / 1ps
// Port     Dir  Handshake         Word
// in_*     in   push / full       in_word_t (cmd, entry, position, char, value, last)
// out_*    out  empty / pop       out_word_t (found, match_value, match_index)
// cfg_*    in   we, no wait       cfg_index selects count / exact / prefix
//
// Load items and query items without last are taken whenever full is low and do not raise it.
// A query item with last holds full high until its result is in the output register:
// each probe spends a RAM read and an evaluate step per compared character, plus
// a read and an evaluate per keyword character for the length scan in prefix mode,
// and a search makes up to seven probes.
// Reset is synchronous; stores hold no reset value. A waiting result does not block
// new load items.
module loose_keyword_binary_search_unit import lkbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_word_t   in_word,
  output logic       out_empty,
  input  logic       out_pop,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  logic [CNT_W-1:0]   entry_count_r;
  logic               exact_mode_r;
  logic               prefix_mode_r;
  mem_wr_t            wr;
  logic               req_valid, req_ready, srch_done;
  srch_req_t          req;
  logic [KEY_AW-1:0]  key_raddr;
  logic [7:0]         key_rdata;
  logic [SLOT_AW-1:0] qry_raddr;
  logic [7:0]         qry_rdata;
  logic [ENT_AW-1:0]  val_raddr;
  logic [7:0]         val_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      exact_mode_r  <= 1'b0;
      prefix_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: entry_count_r <= CNT_W'(cfg_wdata);
        CFG_EXACT_MODE:  exact_mode_r  <= cfg_wdata[0];
        CFG_PREFIX_MODE: prefix_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lkbs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_word     (in_word),
    .entry_count (entry_count_r),
    .exact_mode  (exact_mode_r),
    .prefix_mode (prefix_mode_r),
    .wr          (wr),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .srch_done   (srch_done)
  );

  lkbs_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (wr.key_we),
    .waddr (wr.key_waddr),
    .wdata (wr.key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  lkbs_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (wr.val_we),
    .waddr (wr.val_waddr),
    .wdata (wr.val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  lkbs_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_qry_ram (
    .clk   (clk),
    .we    (wr.qry_we),
    .waddr (wr.qry_waddr),
    .wdata (wr.qry_wdata),
    .raddr (qry_raddr),
    .rdata (qry_rdata)
  );

  lkbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .srch_done (srch_done),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .qry_raddr (qry_raddr),
    .qry_rdata (qry_rdata),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  a_done_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    srch_done |-> in_full)
    else $error("search finished while front was not waiting");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_word.cmd == CMD_QUERY && in_word.last) |=> in_full)
    else $error("front took a word while a search was pending");

  a_handoff_once: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> !req_ready)
    else $error("search engine idle right after taking a request");
`endif

endmodule

// File: tb/sv/loose_keyword_binary_search_checker.sv
`timescale 1ns / 1ps
module loose_keyword_binary_search_checker import lkbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  in_word_t   in_word,
  input  logic       out_empty,
  input  logic       out_pop,
  input  out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  output int         errors,
  output int         pending
);

  logic [7:0] kw_mem [TABLE_DEPTH][SLOTS];
  logic [7:0] val_mem [TABLE_DEPTH];
  logic [7:0] qry_mem [SLOTS];
  logic [6:0] count_reg;
  logic       exact_reg;
  logic       prefix_reg;
  out_word_t  lookups_due [$];

  initial errors = 0;
  assign pending = lookups_due.size();

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? (c & CASE_MASK) : c;
  endfunction

  function automatic int keyword_len(input int e);
    int n;
    n = 0;
    while (n < SLOTS && kw_mem[e][n] != 8'd0) n++;
    return n;
  endfunction

  // sign says whether the query orders before, on or after entry e
  function automatic int order_vs_entry(input int e, input int lim, input logic ex);
    int si, ti, left, diff;
    logic [7:0] s, t, cs, ct;
    si = 0; ti = 0; left = lim; diff = 0;
    while (left > 0) begin
      s = (si < SLOTS) ? qry_mem[si] : 8'd0;
      t = (ti < SLOTS) ? kw_mem[e][ti] : 8'd0;
      left--;
      if (s == t) begin
        if (s == 8'd0) return diff;
        si++; ti++;
        continue;
      end
      if (ex) diff++;
      if (s == CHAR_SPACE) begin
        si++; left++;
        continue;
      end
      if (t == CHAR_SPACE) begin
        ti++; left++;
        continue;
      end
      cs = fold_case(s);
      ct = fold_case(t);
      if (cs == ct) begin
        si++; ti++;
        continue;
      end
      return int'(cs) - int'(ct);
    end
    return diff;
  endfunction

  function automatic out_word_t lookup_query();
    out_word_t r;
    int lo, hi, mid, ord, lim;
    r = '0;
    lo = 0;
    hi = ((count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      lim = prefix_reg ? keyword_len(mid) : MAX_CHARS;
      ord = order_vs_entry(mid, lim, exact_reg);
      if (ord < 0) hi = mid - 1;
      else if (ord > 0) lo = mid + 1;
      else begin
        r.found = 1'b1;
        r.match_value = val_mem[mid];
        r.match_index = mid[5:0];
        break;
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (errors < 40) $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      count_reg <= '0;
      exact_reg <= 1'b0;
      prefix_reg <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENTRY_COUNT: count_reg <= cfg_wdata;
          CFG_EXACT_MODE: exact_reg <= cfg_wdata[0];
          CFG_PREFIX_MODE: prefix_reg <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        case (cmd_t'(in_word.cmd))
          CMD_KEY_CHAR: if (in_word.position < SLOTS)
            kw_mem[in_word.entry][in_word.position] = in_word.char_code;
          CMD_VALUE: val_mem[in_word.entry] = in_word.entry_value;
          CMD_QUERY: begin
            if (in_word.position < SLOTS) qry_mem[in_word.position] = in_word.char_code;
            if (in_word.last) begin
              if (in_word.position + 1 < SLOTS) qry_mem[in_word.position + 1] = 8'd0;
              lookups_due.push_back(lookup_query());
            end
          end
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (lookups_due.size() == 0) report("unexpected word", 0, 0);
        else begin
          want = lookups_due.pop_front();
          if (out_word.found !== want.found) report("found", out_word.found, want.found);
          if (out_word.match_value !== want.match_value)
            report("match_value", out_word.match_value, want.match_value);
          if (out_word.match_index !== want.match_index)
            report("match_index", out_word.match_index, want.match_index);
        end
      end
    end
  end

endmodule

// File: tb/sv/loose_keyword_binary_search_unit_test.sv
`timescale 1ns / 1ps
module loose_keyword_binary_search_unit_test;
  import lkbs_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  in_word_t   in_word;
  logic       out_empty;
  logic       out_pop;
  out_word_t  out_word;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;
  int         errors;
  int         pending;
  int         sent;
  logic [7:0] key_chars [TABLE_DEPTH][SLOTS];
  int         key_len [TABLE_DEPTH];
  int         table_size;
  logic       exact_now;

  loose_keyword_binary_search_unit DUT (.*);

  loose_keyword_binary_search_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // pop side: bursts of steady popping, random stalls, a few long holds
  initial begin
    int g;
    out_pop = 1'b0;
    forever begin
      out_pop = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_pop = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // drive at negedge; full seen at negedge holds through the next rising edge
  task automatic send(input in_word_t w, input bit nogap = 0);
    int g;
    g = nogap ? 0 : pick_gap();
    if (g > 0) begin
      in_push = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_push = 1'b1;
    in_word = w;
    while (in_full) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic in_word_t make_word(input cmd_t c, input int e, input int p,
                                         input int ch, input int v, input bit lst);
    in_word_t w;
    w.cmd = c;
    w.entry = 6'(e);
    w.position = 6'(p);
    w.char_code = 8'(ch);
    w.entry_value = 8'(v);
    w.last = lst;
    return w;
  endfunction

  task automatic write_cfg(input cfg_idx_t idx, input int data);
    cfg_index = idx;
    cfg_wdata = 7'(data);
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic setup(input int count, input bit ex, input bit pre);
    wait_idle();
    write_cfg(CFG_ENTRY_COUNT, count);
    write_cfg(CFG_EXACT_MODE, ex);
    write_cfg(CFG_PREFIX_MODE, pre);
    exact_now = ex;
  endtask

  function automatic bit key_less(input int a, input int b);
    for (int i = 0; i < SLOTS; i++) begin
      if (i >= key_len[a]) return i < key_len[b];
      if (i >= key_len[b]) return 1'b0;
      if (key_chars[a][i] != key_chars[b][i]) return key_chars[a][i] < key_chars[b][i];
    end
    return 1'b0;
  endfunction

  // build n sorted uppercase keys, optionally an empty first one and an
  // unterminated long last one, then lowercase some letters and load
  task automatic load_table(input int n, input bit with_empty, input bit with_long);
    logic [7:0] tmp [SLOTS];
    int tl;
    table_size = n;
    for (int e = 0; e < n; e++) begin
      key_len[e] = $urandom_range(1, 6);
      for (int i = 0; i < key_len[e]; i++) key_chars[e][i] = 8'(8'h41 + $urandom_range(0, 5));
    end
    for (int i = 1; i < n; i++)
      for (int j = i; j > 0 && key_less(j, j - 1); j--) begin
        tmp = key_chars[j]; key_chars[j] = key_chars[j - 1]; key_chars[j - 1] = tmp;
        tl = key_len[j]; key_len[j] = key_len[j - 1]; key_len[j - 1] = tl;
      end
    if (with_empty && n > 0) key_len[0] = 0;
    if (with_long && n > 1) begin
      key_len[n - 1] = SLOTS;
      for (int i = 0; i < SLOTS; i++) key_chars[n - 1][i] = "Z";
    end
    for (int e = 0; e < n; e++) begin
      for (int i = 0; i < key_len[e]; i++) begin
        if ($urandom_range(0, 2) == 0) key_chars[e][i] |= 8'h20;
        send(make_word(CMD_KEY_CHAR, e, i, key_chars[e][i], $urandom, 0));
      end
      if (key_len[e] < SLOTS)
        send(make_word(CMD_KEY_CHAR, e, key_len[e], 0, $urandom, $urandom));
      send(make_word(CMD_VALUE, e, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic send_query(input logic [7:0] q [40], input int n);
    for (int i = 0; i < n; i++)
      send(make_word(CMD_QUERY, $urandom, i, q[i], $urandom, i == n - 1));
  endtask

  task automatic random_query();
    logic [7:0] q [40];
    int n, k, r;
    n = 0;
    r = $urandom_range(0, 99);
    if (r < 70 && table_size > 0) begin
      k = $urandom_range(0, table_size - 1);
      for (int i = 0; i < key_len[k] && n < SLOTS; i++) begin
        if (!exact_now && $urandom_range(0, 7) == 0 && n < SLOTS - 1) q[n++] = CHAR_SPACE;
        q[n] = key_chars[k][i];
        if (!exact_now && $urandom_range(0, 3) == 0) q[n] ^= 8'h20;
        n++;
      end
      if (r >= 55 && n < SLOTS) q[n++] = 8'(8'h41 + $urandom_range(0, 25));
      if (r >= 45 && r < 55 && n > 1) n--;
    end else if (r < 88) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        q[i] = 8'(8'h41 + $urandom_range(0, 5) + 8'h20 * $urandom_range(0, 1));
    end else begin
      n = $urandom_range(1, SLOTS);
      for (int i = 0; i < n; i++) q[i] = 8'($urandom);
    end
    if (n == 0) begin
      q[0] = 8'h61;
      n = 1;
    end
    send_query(q, n);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: send(make_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom));
      1: send(make_word(CMD_KEY_CHAR, $urandom, $urandom_range(SLOTS, 63), $urandom,
                        $urandom, $urandom));
      2: send(make_word(CMD_QUERY, $urandom, $urandom_range(SLOTS, 63), $urandom,
                        $urandom, 0));
      default: send(make_word(CMD_QUERY, $urandom, $urandom_range(SLOTS, 63), $urandom,
                              $urandom, 1));
    endcase
  endtask

  initial begin
    logic [7:0] q [40];
    int cnt;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENTRY_COUNT;
    cfg_wdata = '0;
    sent = 0;
    exact_now = 1'b0;
    table_size = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // fill every key and value store slot once so no search reads an unwritten one
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      for (int i = 0; i < SLOTS; i++)
        send(make_word(CMD_KEY_CHAR, e, i, $urandom_range(1, 255), 0, 0), 1);
      send(make_word(CMD_VALUE, e, 0, 0, $urandom, 0), 1);
    end
    // full query without terminator, on an empty table
    for (int i = 0; i < SLOTS; i++) q[i] = 8'($urandom_range(1, 255));
    send_query(q, SLOTS);

    // directed: extremes, modes, blanks, case, prefix, range drops
    setup(64, 0, 0);
    load_table(64, 1, 1);
    for (int i = 0; i < key_len[5]; i++) q[i] = key_chars[5][i] ^ 8'h20;
    send_query(q, key_len[5]);
    q[0] = CHAR_SPACE;
    for (int i = 0; i < key_len[9]; i++) q[i + 1] = key_chars[9][i];
    send_query(q, key_len[9] + 1);
    for (int i = 0; i < SLOTS; i++) q[i] = "z";
    send_query(q, SLOTS);
    send(make_word(CMD_QUERY, 63, 63, 255, 255, 1));
    send(make_word(CMD_UNUSED, 63, 63, 255, 255, 1));
    q[0] = 8'h00;
    send_query(q, 1);
    setup(127, 1, 1);
    for (int i = 0; i < key_len[20]; i++) q[i] = key_chars[20][i];
    q[key_len[20]] = "Q";
    send_query(q, key_len[20] + 1);
    q[0] = 8'hFF;
    send_query(q, 1);
    setup(1, 0, 1);
    q[0] = "M";
    send_query(q, 1);
    setup(0, 1, 0);
    send_query(q, 1);

    while (sent < 2176 + 33 + 1500 + 40) begin
      case ($urandom_range(0, 5))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 64;
        3: cnt = $urandom_range(65, 127);
        default: cnt = $urandom_range(2, 64);
      endcase
      setup(cnt, $urandom_range(0, 1), $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0 || cnt == 0)
        ;
      else
        load_table((cnt > 64) ? 64 : cnt, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 25)) begin
        if ($urandom_range(0, 9) == 0) noise_item();
        else random_query();
      end
    end

    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lkbs_pkg.sv
hw/rtl/lkbs_ram.sv
hw/rtl/lkbs_front.sv
hw/rtl/lkbs_back.sv
hw/rtl/loose_keyword_binary_search_unit.sv
tb/sv/loose_keyword_binary_search_checker.sv
tb/sv/loose_keyword_binary_search_unit_test.sv
